// ----- rtl/bfer_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bfer_pkg
// Shared constants and controller/datapath interface types for the
// Bellman-Ford edge relaxation engine.
// ----------------------------------------------------------------------------
package bfer_pkg;

   // Default configuration
   localparam int DEFAULT_NODE_COUNT = 1024;
   localparam int DEFAULT_DIST_WIDTH = 32;

   // Fixed field widths
   localparam int ACTION_W   = 2;
   localparam int NODE_W     = 10;
   localparam int WEIGHT_W   = 16;
   localparam int DIST_OUT_W = 32;
   localparam int CHECKSUM_W = 64;

   // Action codes (code 3 behaves as a read)
   localparam logic [ACTION_W-1:0] ACT_RELAX   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_RESTART = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_READ    = 2'd2;

   // Controller to datapath commands
   typedef struct packed {
      logic clear_init;    // rewind clear pointer, zero checksum
      logic clear_step;    // write one table entry to its reset value
      logic capture;       // latch request, issue both table reads
      logic exec;          // relax/read, write back, load response
      logic load_restart;  // load the response of a restart transaction
   } bfer_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic clear_done;    // clear pointer is on the last entry
      logic is_restart;    // captured transaction is a restart
   } bfer_status_type;

endpackage
`default_nettype wire

// ----- rtl/bfer_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bfer_ctrl
// Sequencer for the relaxation engine: clearing pass, capture, execute, and
// the response valid flag.
// ----------------------------------------------------------------------------
module bfer_ctrl (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  wire                      rsp_ready,
   output bfer_pkg::bfer_cmd_type   cmd,
   input  wire bfer_pkg::bfer_status_type status
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      pending_ff, pending_in;   // restart waiting for its response
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      pending_in   = pending_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_done) begin
               state_in = ST_IDLE;
               if (pending_ff) begin
                  cmd.load_restart = 1'b1;
                  rsp_valid_in     = 1'b1;
                  pending_in       = 1'b0;
               end
            end
         end
         ST_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (status.is_restart) begin
               cmd.clear_init = 1'b1;
               pending_in     = 1'b1;
               state_in       = ST_CLEAR;
            end else begin
               cmd.exec     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
         pending_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pending_ff   <= pending_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/bfer_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bfer_datapath
// Distance table memory, relax compare, checksum and response registers.
// ----------------------------------------------------------------------------
module bfer_datapath #(
   parameter int NODE_COUNT = bfer_pkg::DEFAULT_NODE_COUNT,
   parameter int DIST_WIDTH = bfer_pkg::DEFAULT_DIST_WIDTH
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire bfer_pkg::bfer_cmd_type          cmd,
   output bfer_pkg::bfer_status_type            status,
   input  wire [bfer_pkg::ACTION_W-1:0]         req_action,
   input  wire [bfer_pkg::NODE_W-1:0]           req_source_node,
   input  wire [bfer_pkg::NODE_W-1:0]           req_target_node,
   input  wire [bfer_pkg::WEIGHT_W-1:0]         req_edge_weight,
   output logic [bfer_pkg::DIST_OUT_W-1:0]      rsp_node_distance,
   output logic                                 rsp_relaxed,
   output logic [bfer_pkg::CHECKSUM_W-1:0]      rsp_weight_checksum
);

   localparam int ADDR_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
   localparam int SUM_W  = ((DIST_WIDTH > bfer_pkg::WEIGHT_W) ?
                            DIST_WIDTH : bfer_pkg::WEIGHT_W) + 1;
   localparam logic [DIST_WIDTH-1:0] INF_DIST = '1;
   localparam logic [ADDR_W-1:0]     LAST_ADDR = ADDR_W'(NODE_COUNT - 1);

   logic [DIST_WIDTH-1:0] dist_mem [NODE_COUNT];

   // Captured transaction
   logic [bfer_pkg::ACTION_W-1:0] action_ff;
   logic [bfer_pkg::NODE_W-1:0]   dst_node_ff;
   logic [bfer_pkg::WEIGHT_W-1:0] weight_ff;
   logic [ADDR_W-1:0]             dst_addr_ff;
   logic                          src_ok_ff;
   logic                          dst_ok_ff;
   logic [DIST_WIDTH-1:0]         src_rd_ff;
   logic [DIST_WIDTH-1:0]         dst_rd_ff;

   // Control state
   logic [ADDR_W-1:0]               clr_addr_ff, clr_addr_in;
   logic [bfer_pkg::CHECKSUM_W-1:0] checksum_ff, checksum_in;

   logic                  src_ok, dst_ok;
   logic [ADDR_W-1:0]     src_addr, dst_addr;
   logic [DIST_WIDTH-1:0] du, dv, new_dist, clr_data;
   logic [SUM_W-1:0]      sum;
   logic                  is_relax, improve;
   logic                  mem_we;
   logic [ADDR_W-1:0]     mem_waddr;
   logic [DIST_WIDTH-1:0] mem_wdata;

   // Nodes beyond the table read as infinity and are never written
   assign src_ok   = 32'(req_source_node) < 32'(NODE_COUNT);
   assign dst_ok   = 32'(req_target_node) < 32'(NODE_COUNT);
   assign src_addr = ADDR_W'(req_source_node);
   assign dst_addr = ADDR_W'(req_target_node);

   assign is_relax = (action_ff == bfer_pkg::ACT_RELAX);
   assign du       = src_ok_ff ? src_rd_ff : INF_DIST;
   assign dv       = dst_ok_ff ? dst_rd_ff : INF_DIST;
   assign sum      = SUM_W'(du) + SUM_W'(weight_ff);
   // A sum at or above infinity is no improvement; an infinite source lands here
   assign improve  = is_relax && dst_ok_ff && (sum < SUM_W'(INF_DIST)) &&
                     (sum < SUM_W'(dv));
   assign new_dist = improve ? DIST_WIDTH'(sum) : dv;

   assign clr_data = (clr_addr_ff == '0) ? '0 : INF_DIST;

   assign mem_we    = cmd.clear_step || (cmd.exec && improve);
   assign mem_waddr = cmd.clear_step ? clr_addr_ff : dst_addr_ff;
   assign mem_wdata = cmd.clear_step ? clr_data : new_dist;

   assign status.clear_done = (clr_addr_ff == LAST_ADDR);
   assign status.is_restart = (action_ff == bfer_pkg::ACT_RESTART);

   always_comb begin
      clr_addr_in = clr_addr_ff;
      checksum_in = checksum_ff;
      if (cmd.clear_init) begin
         clr_addr_in = '0;
         checksum_in = '0;
      end else if (cmd.clear_step) begin
         clr_addr_in = status.clear_done ? '0 : clr_addr_ff + ADDR_W'(1);
      end else if (cmd.exec && is_relax) begin
         checksum_in = checksum_ff + bfer_pkg::CHECKSUM_W'(weight_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         checksum_ff <= '0;
      end else begin
         clr_addr_ff <= clr_addr_in;
         checksum_ff <= checksum_in;
      end
   end

   // Table memory: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (mem_we) begin
         dist_mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.capture) begin
         src_rd_ff <= dist_mem[src_addr];
         dst_rd_ff <= dist_mem[dst_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff   <= req_action;
         dst_node_ff <= req_target_node;
         weight_ff   <= req_edge_weight;
         dst_addr_ff <= dst_addr;
         src_ok_ff   <= src_ok;
         dst_ok_ff   <= dst_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rsp_node_distance   <= bfer_pkg::DIST_OUT_W'(new_dist);
         rsp_relaxed         <= improve;
         rsp_weight_checksum <= checksum_in;
      end else if (cmd.load_restart) begin
         rsp_node_distance   <= (dst_node_ff == '0) ? '0 :
                                bfer_pkg::DIST_OUT_W'(INF_DIST);
         rsp_relaxed         <= 1'b0;
         rsp_weight_checksum <= '0;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/bellman_ford_edge_relax.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bellman_ford_edge_relax
// Bellman-Ford edge relaxation engine: keeps a table of node distances,
// relaxes edges, restarts the table and answers distance reads.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------
//   req     | in        | req_valid/req_ready  | action, source_node,
//           |           |                      | target_node, edge_weight
//   rsp     | out       | rsp_valid/rsp_ready  | node_distance, relaxed,
//           |           |                      | weight_checksum
//
// Relax and read transactions capture the request and read both distances
// from the dual-read table memory, then compare, write back and load the
// response register. Restart sweeps the table one entry a cycle; after
// reset the same sweep runs with req_ready low.
// A waiting response holds off the next request until it is taken: req_ready
// is high again in the cycle the response is accepted.
// ----------------------------------------------------------------------------
module bellman_ford_edge_relax #(
   parameter int NODE_COUNT = bfer_pkg::DEFAULT_NODE_COUNT,
   parameter int DIST_WIDTH = bfer_pkg::DEFAULT_DIST_WIDTH
) (
   input  wire                               clock,
   input  wire                               reset,
   // request channel
   input  wire                               req_valid,
   output logic                              req_ready,
   input  wire [bfer_pkg::ACTION_W-1:0]      req_action,
   input  wire [bfer_pkg::NODE_W-1:0]        req_source_node,
   input  wire [bfer_pkg::NODE_W-1:0]        req_target_node,
   input  wire [bfer_pkg::WEIGHT_W-1:0]      req_edge_weight,
   // response channel
   output logic                              rsp_valid,
   input  wire                               rsp_ready,
   output logic [bfer_pkg::DIST_OUT_W-1:0]   rsp_node_distance,
   output logic                              rsp_relaxed,
   output logic [bfer_pkg::CHECKSUM_W-1:0]   rsp_weight_checksum
);

   // Command and status between sequencer and datapath
   bfer_pkg::bfer_cmd_type    cmd;
   bfer_pkg::bfer_status_type status;

   // Sequencer: clearing pass, capture, execute, response valid
   bfer_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   // Datapath: distance memory, relax compare, checksum, response payload
   bfer_datapath #(
      .NODE_COUNT (NODE_COUNT),
      .DIST_WIDTH (DIST_WIDTH)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_action          (req_action),
      .req_source_node     (req_source_node),
      .req_target_node     (req_target_node),
      .req_edge_weight     (req_edge_weight),
      .rsp_node_distance   (rsp_node_distance),
      .rsp_relaxed         (rsp_relaxed),
      .rsp_weight_checksum (rsp_weight_checksum)
   );

endmodule
`default_nettype wire
